@@ sv/sfp_pkg.sv @@
// ----------------------------------------------------------------------------
// sfp_pkg
// Shared types, codes and tables of the sequence parameter set size parser.
// ----------------------------------------------------------------------------
package sfp_pkg;

    localparam int DEF_MAX_PREFIX_ZEROS = 16;
    localparam int DEF_MAX_POC_CYCLE    = 255;

    localparam logic [7:0] HIGH_PROFILE = 8'd100;
    localparam logic [4:0] SPS_NAL_TYPE = 5'd7;
    localparam logic [7:0] EPB_BYTE     = 8'd3;
    localparam int         SZ_W         = 24;

    localparam logic [2:0] STAT_OK      = 3'd0;
    localparam logic [2:0] STAT_NOT_SPS = 3'd1;
    localparam logic [2:0] STAT_TRUNC   = 3'd2;
    localparam logic [2:0] STAT_LONG    = 3'd3;
    localparam logic [2:0] STAT_BAD     = 3'd4;

    typedef enum logic [5:0] {
        ST_HDR, ST_PROF, ST_CS, ST_RSV, ST_LEVEL, ST_ID, ST_CHROMA, ST_SEP,
        ST_BDL, ST_BDC, ST_QP, ST_SCM, ST_SLF, ST_LOG2FN, ST_POCT, ST_POCLSB,
        ST_DPAZ, ST_ONRP, ST_OTTB, ST_NCYC, ST_OREF, ST_NREF, ST_GAPS, ST_WID,
        ST_HGT, ST_FMO, ST_MBAFF, ST_D8, ST_CROP, ST_CL, ST_CR, ST_CT, ST_CB,
        ST_DONE
    } t_step;

    typedef enum logic [2:0] {
        S_IDLE, S_BITS, S_EVAL, S_SIZE, S_LOAD
    } t_ctl_state;

    typedef enum logic [2:0] {
        SZ_IDLE, SZ_WSUM, SZ_WSUB, SZ_HSUM, SZ_HSUB, SZ_DONE
    } t_size_state;

    typedef struct packed {
        logic [16:0] width_units;
        logic [16:0] height_units;
        logic [16:0] crop_l;
        logic [16:0] crop_r;
        logic [16:0] crop_t;
        logic [16:0] crop_b;
        logic        crop_on;
        logic        frame_only;
        logic [1:0]  chroma;
    } t_size_in;

    typedef struct packed {
        logic       at_hdr;
        logic       done;
        logic [2:0] err;
        logic [7:0] profile;
        logic [7:0] level;
        logic [2:0] flags;
        logic [4:0] id;
        t_size_in   size;
    } t_parse_info;

    // 0 means exp-golomb, otherwise fixed width in bits
    function automatic logic [3:0] f_field_width(input t_step s);
        logic [3:0] w;
        w = 4'd0;
        case (s)
            ST_PROF, ST_LEVEL:                       w = 4'd8;
            ST_RSV:                                  w = 4'd5;
            ST_CS:                                   w = 4'd3;
            ST_SEP, ST_QP, ST_SCM, ST_SLF, ST_DPAZ,
            ST_GAPS, ST_FMO, ST_MBAFF, ST_D8,
            ST_CROP:                                 w = 4'd1;
            default:                                 w = 4'd0;
        endcase
        return w;
    endfunction

endpackage

@@ sv/sfp_bit_parser.sv @@
// ----------------------------------------------------------------------------
// sfp_bit_parser
// Consumes one payload bit per cycle while i_bit_valid is high and decodes fixed and exp-golomb fields.
// ----------------------------------------------------------------------------
module sfp_bit_parser #(
    parameter int MAX_PREFIX_ZEROS = 16,
    parameter int MAX_POC_CYCLE    = 255
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_hdr_load,
    input  logic [7:0]         i_hdr_byte,
    input  logic               i_bit_valid,
    input  logic               i_bit,
    input  logic               i_rearm,
    output sfp_pkg::t_parse_info o_info
);
    import sfp_pkg::*;

    t_step       r_step, n_step;
    logic [4:0]  r_lz, n_lz, r_bl, n_bl, r_id, n_id;
    logic [16:0] r_acc, n_acc, r_wu, n_wu, r_hu, n_hu;
    logic [7:0]  r_lc, n_lc, r_profile, n_profile, r_level, n_level;
    logic [2:0]  r_flags, n_flags, r_err, n_err;
    logic [1:0]  r_chroma, n_chroma;
    logic        r_frame_only, n_frame_only, r_crop_on, n_crop_on;
    logic [16:0] r_crop [4];
    logic [16:0] n_crop [4];

    logic        fin, ferr;
    logic [16:0] v, acc_sh;
    logic [7:0]  acc8, lc_inc, lc_dec;
    t_step       nx;

    always_comb begin
        n_step = r_step; n_lz = r_lz; n_bl = r_bl; n_acc = r_acc; n_lc = r_lc;
        n_profile = r_profile; n_level = r_level; n_flags = r_flags; n_id = r_id;
        n_chroma = r_chroma; n_frame_only = r_frame_only; n_crop_on = r_crop_on;
        n_wu = r_wu; n_hu = r_hu; n_err = r_err;
        for (int k = 0; k < 4; k++) n_crop[k] = r_crop[k];
        fin = 1'b0; ferr = 1'b0; v = '0; nx = ST_DONE;
        acc8 = {r_acc[6:0], i_bit};
        acc_sh = (r_acc > 17'h0FFFF) ? 17'h1FFFF : {r_acc[15:0], i_bit};
        lc_inc = r_lc + 8'd1;
        lc_dec = r_lc - 8'd1;

        if (i_rearm) begin
            n_step = ST_HDR;
        end else if (i_hdr_load) begin
            n_lz = '0; n_bl = '0; n_acc = '0; n_lc = '0; n_profile = '0;
            n_level = '0; n_flags = '0; n_id = '0; n_chroma = 2'd1;
            n_frame_only = 1'b0; n_crop_on = 1'b0; n_wu = '0; n_hu = '0;
            n_err = STAT_OK;
            for (int k = 0; k < 4; k++) n_crop[k] = '0;
            if (i_hdr_byte[4:0] != SPS_NAL_TYPE) begin
                n_err  = STAT_NOT_SPS;
                n_step = ST_DONE;
            end else begin
                n_step = ST_PROF;
                n_bl   = {1'b0, f_field_width(ST_PROF)};
            end
        end else if (i_bit_valid && r_err == STAT_OK && r_step != ST_DONE) begin
            if (f_field_width(r_step) != 4'd0) begin
                n_acc = {9'd0, acc8};
                n_bl  = r_bl - 5'd1;
                fin   = (r_bl == 5'd1);
                v     = {9'd0, acc8};
            end else if (r_acc == '0) begin
                if (!i_bit) begin
                    if (r_lz >= 5'(MAX_PREFIX_ZEROS)) n_err = STAT_LONG;
                    else n_lz = r_lz + 5'd1;
                end else begin
                    n_acc = 17'd1;
                    n_bl  = r_lz;
                    fin   = (r_lz == 5'd0);
                    v     = '0;
                end
            end else begin
                n_acc = acc_sh;
                n_bl  = r_bl - 5'd1;
                fin   = (r_bl == 5'd1);
                v     = acc_sh - 17'd1;
            end

            if (fin) begin
                case (r_step)
                    ST_PROF:  begin n_profile = v[7:0]; nx = ST_CS; end
                    ST_CS:    begin n_flags = v[2:0]; nx = ST_RSV; end
                    ST_RSV:   nx = ST_LEVEL;
                    ST_LEVEL: begin n_level = v[7:0]; nx = ST_ID; end
                    ST_ID: begin
                        ferr = (v > 17'd31);
                        n_id = v[4:0];
                        nx   = (r_profile == HIGH_PROFILE) ? ST_CHROMA : ST_LOG2FN;
                    end
                    ST_CHROMA: begin
                        ferr     = (v > 17'd3);
                        n_chroma = v[1:0];
                        nx       = (v == 17'd3) ? ST_SEP : ST_BDL;
                    end
                    ST_SEP:   nx = ST_BDL;
                    ST_BDL:   nx = ST_BDC;
                    ST_BDC:   nx = ST_QP;
                    ST_QP:    nx = ST_SCM;
                    ST_SCM: begin
                        n_lc = '0;
                        nx   = v[0] ? ST_SLF : ST_LOG2FN;
                    end
                    ST_SLF: begin
                        n_lc = lc_inc;
                        nx   = (lc_inc >= 8'd8) ? ST_LOG2FN : ST_SLF;
                    end
                    ST_LOG2FN: nx = ST_POCT;
                    ST_POCT: begin
                        if (v == 17'd0)      nx = ST_POCLSB;
                        else if (v == 17'd1) nx = ST_DPAZ;
                        else if (v == 17'd2) nx = ST_NREF;
                        else                 ferr = 1'b1;
                    end
                    ST_POCLSB: nx = ST_NREF;
                    ST_DPAZ:   nx = ST_ONRP;
                    ST_ONRP:   nx = ST_OTTB;
                    ST_OTTB:   nx = ST_NCYC;
                    ST_NCYC: begin
                        ferr = (v > 17'(MAX_POC_CYCLE));
                        n_lc = v[7:0];
                        nx   = (v != '0) ? ST_OREF : ST_NREF;
                    end
                    ST_OREF: begin
                        n_lc = lc_dec;
                        nx   = (lc_dec != '0) ? ST_OREF : ST_NREF;
                    end
                    ST_NREF:  nx = ST_GAPS;
                    ST_GAPS:  nx = ST_WID;
                    ST_WID:   begin n_wu = v + 17'd1; nx = ST_HGT; end
                    ST_HGT:   begin n_hu = v + 17'd1; nx = ST_FMO; end
                    ST_FMO: begin
                        n_frame_only = v[0];
                        nx = v[0] ? ST_D8 : ST_MBAFF;
                    end
                    ST_MBAFF: nx = ST_D8;
                    ST_D8:    nx = ST_CROP;
                    ST_CROP: begin
                        n_crop_on = v[0];
                        nx = v[0] ? ST_CL : ST_DONE;
                    end
                    ST_CL:   begin n_crop[0] = v; nx = ST_CR; end
                    ST_CR:   begin n_crop[1] = v; nx = ST_CT; end
                    ST_CT:   begin n_crop[2] = v; nx = ST_CB; end
                    ST_CB:   begin n_crop[3] = v; nx = ST_DONE; end
                    default: nx = ST_DONE;
                endcase
                if (ferr) begin
                    n_err = STAT_BAD;
                    // a failed check leaves the id and chroma untouched
                    n_id = r_id; n_chroma = r_chroma; n_lc = r_lc;
                end else begin
                    n_step = nx;
                    n_lz   = '0;
                    n_acc  = '0;
                    n_bl   = {1'b0, f_field_width(nx)};
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= ST_HDR; r_lz <= '0; r_bl <= '0; r_acc <= '0; r_lc <= '0;
            r_profile <= '0; r_level <= '0; r_flags <= '0; r_id <= '0;
            r_chroma <= 2'd1; r_frame_only <= 1'b0; r_crop_on <= 1'b0;
            r_wu <= '0; r_hu <= '0; r_err <= STAT_OK;
            for (int k = 0; k < 4; k++) r_crop[k] <= '0;
        end else begin
            r_step <= n_step; r_lz <= n_lz; r_bl <= n_bl; r_acc <= n_acc; r_lc <= n_lc;
            r_profile <= n_profile; r_level <= n_level; r_flags <= n_flags;
            r_id <= n_id; r_chroma <= n_chroma; r_frame_only <= n_frame_only;
            r_crop_on <= n_crop_on; r_wu <= n_wu; r_hu <= n_hu; r_err <= n_err;
            for (int k = 0; k < 4; k++) r_crop[k] <= n_crop[k];
        end
    end

    always_comb begin
        o_info.at_hdr            = (r_step == ST_HDR);
        o_info.done              = (r_step == ST_DONE);
        o_info.err               = r_err;
        o_info.profile           = r_profile;
        o_info.level             = r_level;
        o_info.flags             = r_flags;
        o_info.id                = r_id;
        o_info.size.width_units  = r_wu;
        o_info.size.height_units = r_hu;
        o_info.size.crop_l       = r_crop[0];
        o_info.size.crop_r       = r_crop[1];
        o_info.size.crop_t       = r_crop[2];
        o_info.size.crop_b       = r_crop[3];
        o_info.size.crop_on      = r_crop_on;
        o_info.size.frame_only   = r_frame_only;
        o_info.size.chroma       = r_chroma;
    end

endmodule

@@ sv/sfp_size_calc.sv @@
// ----------------------------------------------------------------------------
// sfp_size_calc
// Cropped frame size from one shared add/subtract unit, width then height.
// ----------------------------------------------------------------------------
module sfp_size_calc (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  sfp_pkg::t_size_in i_size,
    output logic              o_done,
    output logic              o_bad,
    output logic [15:0]       o_width,
    output logic [15:0]       o_height
);
    import sfp_pkg::*;

    t_size_state            r_state, n_state;
    logic signed [SZ_W-1:0] r_t, r_w, r_h;
    logic signed [SZ_W-1:0] op_a, op_b, sum;
    logic                   op_sub;
    logic                   sw_sh, sh_sh, fm_sh;

    // chroma subsampling and field factors are all powers of two
    assign sw_sh = (i_size.chroma == 2'd1) || (i_size.chroma == 2'd2);
    assign sh_sh = (i_size.chroma == 2'd1);
    assign fm_sh = !i_size.frame_only;

    always_comb begin
        op_a = '0; op_b = '0; op_sub = 1'b0;
        unique case (r_state)
            SZ_WSUM: begin
                op_a = SZ_W'(i_size.crop_l);
                op_b = SZ_W'(i_size.crop_r);
            end
            SZ_WSUB: begin
                op_a   = SZ_W'(i_size.width_units) <<< 4;
                op_b   = i_size.crop_on ? (r_t <<< sw_sh) : '0;
                op_sub = 1'b1;
            end
            SZ_HSUM: begin
                op_a = SZ_W'(i_size.crop_t);
                op_b = SZ_W'(i_size.crop_b);
            end
            SZ_HSUB: begin
                op_a   = (SZ_W'(i_size.height_units) <<< 4) <<< fm_sh;
                op_b   = i_size.crop_on ? ((r_t <<< sh_sh) <<< fm_sh) : '0;
                op_sub = 1'b1;
            end
            default: begin
                op_a = '0;
            end
        endcase
        sum = op_a + (op_sub ? ~op_b : op_b) + SZ_W'(op_sub);
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            SZ_IDLE: if (i_start) n_state = SZ_WSUM;
            SZ_WSUM: n_state = SZ_WSUB;
            SZ_WSUB: n_state = SZ_HSUM;
            SZ_HSUM: n_state = SZ_HSUB;
            SZ_HSUB: n_state = SZ_DONE;
            SZ_DONE: n_state = SZ_IDLE;
            default: n_state = SZ_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= SZ_IDLE;
        end else begin
            r_state <= n_state;
        end
        if (r_state == SZ_WSUM || r_state == SZ_HSUM) r_t <= sum;
        if (r_state == SZ_WSUB) r_w <= sum;
        if (r_state == SZ_HSUB) r_h <= sum;
    end

    assign o_done   = (r_state == SZ_DONE);
    assign o_bad    = (r_w < 0) || (r_w > 65535) || (r_h < 0) || (r_h > 65535);
    assign o_width  = r_w[15:0];
    assign o_height = r_h[15:0];

endmodule

@@ sv/sps_frame_size_parser.sv @@
// ----------------------------------------------------------------------------
// sps_frame_size_parser
// H.264 sequence parameter set parser reporting the cropped frame size.
// ----------------------------------------------------------------------------
// Bytes of one NAL unit arrive header first; the block strips emulation
// prevention bytes and decodes the payload one bit per clock through a single
// field decoder, so ready stays low until all bits of a payload byte are
// decoded, while the header byte, a stripped byte and bytes after an error
// are taken straight from idle. On the last byte the status is registered and,
// for a clean parse, the size is worked out by a shared add/subtract unit,
// then the result lands in the output register; a failed parse skips the
// size step, and the load waits while an earlier result is still unread.
module sps_frame_size_parser #(
    parameter int MAX_PREFIX_ZEROS = sfp_pkg::DEF_MAX_PREFIX_ZEROS,
    parameter int MAX_POC_CYCLE    = sfp_pkg::DEF_MAX_POC_CYCLE
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_nal_byte,
    input  logic        i_last_byte,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [2:0]  o_status,
    output logic [7:0]  o_profile,
    output logic [7:0]  o_level,
    output logic [2:0]  o_constraint_bits,
    output logic [4:0]  o_param_set_id,
    output logic [1:0]  o_chroma_format,
    output logic [15:0] o_frame_width,
    output logic [15:0] o_frame_height
);
    import sfp_pkg::*;

    t_ctl_state  r_state, n_state;
    t_parse_info info;
    logic [7:0]  r_byte;
    logic        r_last;
    logic [2:0]  r_idx;
    logic [1:0]  r_zr;
    logic [2:0]  r_status;
    logic        r_out_valid;
    logic        acc, active, epb, hdr_load, bit_valid, size_start, rearm, load;
    logic        size_done, size_bad;
    logic [15:0] size_w, size_h;
    logic [2:0]  eval_status;

    sfp_bit_parser #(
        .MAX_PREFIX_ZEROS(MAX_PREFIX_ZEROS),
        .MAX_POC_CYCLE   (MAX_POC_CYCLE)
    ) u_parser (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_hdr_load (hdr_load),
        .i_hdr_byte (i_nal_byte),
        .i_bit_valid(bit_valid),
        .i_bit      (r_byte[r_idx]),
        .i_rearm    (rearm),
        .o_info     (info)
    );

    sfp_size_calc u_size (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (size_start),
        .i_size  (info.size),
        .o_done  (size_done),
        .o_bad   (size_bad),
        .o_width (size_w),
        .o_height(size_h)
    );

    assign acc    = i_valid && o_ready;
    assign active = !info.at_hdr && info.err == STAT_OK && !info.done;
    assign epb    = (r_zr == 2'd2) && (i_nal_byte == EPB_BYTE);
    assign eval_status = (info.err != STAT_OK) ? info.err
                       : (!info.done ? STAT_TRUNC : STAT_OK);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (acc) begin
                    if (active && !epb) n_state = S_BITS;
                    else if (i_last_byte) n_state = S_EVAL;
                end
            end
            S_BITS: if (r_idx == 3'd0) n_state = r_last ? S_EVAL : S_IDLE;
            S_EVAL: n_state = (eval_status == STAT_OK) ? S_SIZE : S_LOAD;
            S_SIZE: if (size_done) n_state = S_LOAD;
            S_LOAD: if (!r_out_valid || i_ready) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_ready    = (r_state == S_IDLE);
        hdr_load   = acc && info.at_hdr;
        bit_valid  = (r_state == S_BITS);
        size_start = (r_state == S_EVAL) && (eval_status == STAT_OK);
        load       = (r_state == S_LOAD) && (!r_out_valid || i_ready);
        rearm      = load;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_zr        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (hdr_load) begin
                r_zr <= '0;
            end else if (acc && active) begin
                if (epb) r_zr <= '0;
                else if (i_nal_byte == 8'd0) r_zr <= (r_zr == 2'd2) ? 2'd2 : r_zr + 2'd1;
                else r_zr <= '0;
            end
            if (load) r_out_valid <= 1'b1;
            else if (i_ready) r_out_valid <= 1'b0;
        end
        if (acc) begin
            r_byte <= i_nal_byte;
            r_last <= i_last_byte;
            r_idx  <= 3'd7;
        end else if (r_state == S_BITS) begin
            r_idx <= r_idx - 3'd1;
        end
        if (r_state == S_EVAL) r_status <= eval_status;
        else if (r_state == S_SIZE && size_done && size_bad) r_status <= STAT_BAD;
        if (load) begin
            o_status          <= r_status;
            o_profile         <= info.profile;
            o_level           <= info.level;
            o_constraint_bits <= info.flags;
            o_param_set_id    <= info.id;
            o_chroma_format   <= info.size.chroma;
            o_frame_width     <= (r_status == STAT_OK) ? size_w : 16'd0;
            o_frame_height    <= (r_status == STAT_OK) ? size_h : 16'd0;
        end
    end

    assign o_valid = r_out_valid;

    // failed parses never report a size
    a_err_no_size: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status != STAT_OK |-> o_frame_width == 16'd0 && o_frame_height == 16'd0)
        else $error("size reported with nonzero status");

    a_bits_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_BITS |-> !o_ready)
        else $error("ready while shifting bits");

    a_size_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        size_done |-> r_state == S_SIZE)
        else $error("size unit finished outside size wait");

    a_start_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        size_start |=> r_status == STAT_OK)
        else $error("size started on failed parse");

endmodule
